/* src/tww_pkg.sv */
package tww_pkg;

  localparam int MAX_WORD_DEF = 32;
  localparam int LW_W         = 10;
  localparam int POS_W        = 11;
  localparam int NEED_W       = POS_W + 1;
  localparam int CMDQ_DEPTH   = 4;
  localparam int OUTQ_DEPTH   = 4;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 10'd80;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SP  = 8'd32;

  typedef enum logic [2:0] {
    OP_STORE,
    OP_DROP,
    OP_FLUSH,
    OP_PARA,
    OP_EOT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] chr;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
    logic       trunc;
  } res_t;

endpackage

/* src/tww_fifo.sv */
module tww_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [WIDTH-1:0]               wr_data,
  output logic                           full,
  input  logic                           rd_en,
  output logic [WIDTH-1:0]               rd_data,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             do_wr;
  logic             do_rd;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign rd_data = mem[rptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

/* src/tww_front.sv */
module tww_front #(
  parameter int MAX_WORD = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          q_full,
  input  logic          action,
  input  logic [7:0]    char_code,
  output logic          cmd_wr,
  output tww_pkg::cmd_t cmd
);

  import tww_pkg::*;

  localparam int LW = $clog2(MAX_WORD + 1);

  logic          nl_seen;
  logic          para_end;
  logic [LW-1:0] fcount;
  logic          white;

  assign cmd_wr = push && !q_full;
  assign white  = (char_code == CH_SP) || (char_code >= CH_TAB && char_code <= CH_CR);

  always_comb begin
    cmd.chr = char_code;
    priority if (action) begin
      cmd.op = OP_EOT;
    end else if (white) begin
      if (char_code == CH_NL && nl_seen && !para_end) begin
        cmd.op = OP_PARA;
      end else begin
        cmd.op = OP_FLUSH;
      end
    end else if (fcount < LW'(MAX_WORD)) begin
      cmd.op = OP_STORE;
    end else begin
      cmd.op = OP_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nl_seen  <= 1'b0;
      para_end <= 1'b0;
      fcount   <= '0;
    end else if (cmd_wr) begin
      priority if (action) begin
        nl_seen  <= 1'b0;
        para_end <= 1'b0;
        fcount   <= '0;
      end else if (white) begin
        fcount <= '0;
        if (char_code == CH_NL) begin
          priority if (!nl_seen) begin
            nl_seen <= 1'b1;
          end else if (!para_end) begin
            nl_seen  <= 1'b0;
            para_end <= 1'b1;
          end
        end
      end else begin
        nl_seen  <= 1'b0;
        para_end <= 1'b0;
        if (fcount < LW'(MAX_WORD)) begin
          fcount <= fcount + 1'b1;
        end
      end
    end
  end

endmodule

/* src/tww_back.sv */
module tww_back #(
  parameter int MAX_WORD   = 32,
  parameter int OUT_DEPTH  = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [tww_pkg::LW_W-1:0]          line_width,
  input  logic                              cmd_empty,
  input  tww_pkg::cmd_t                     cmd,
  output logic                              cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]    res_count,
  output logic                              res_wr,
  output tww_pkg::res_t                     res
);

  import tww_pkg::*;

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CW = $clog2(OUT_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t           state;
  logic [LW-1:0]    len;
  logic [LW-1:0]    wlen;
  logic [LW-1:0]    widx;
  logic [POS_W-1:0] pos;
  logic             pre_valid;
  logic [7:0]       pre_byte;
  logic [1:0]       tail_n;
  logic             ovf;
  logic             trunc;
  logic             s1_valid;
  logic             s1_lit;
  logic [7:0]       s1_byte;
  logic             s1_last;
  logic [7:0]       mem [MAX_WORD];
  logic [7:0]       mem_rdata;

  logic              can_issue;
  logic              word_left;
  logic              run_done;
  logic              issue;
  logic              last_now;
  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] npos;
  logic              brk;
  logic              sp;
  logic              novf;

  assign can_issue = ({1'b0, res_count} + (CW+1)'(s1_valid)) < (CW+1)'(OUT_DEPTH);
  assign cmd_pop   = (state == ST_IDLE) && !cmd_empty;
  assign word_left = widx < wlen;
  assign run_done  = !pre_valid && !word_left && (tail_n == 2'd0);
  assign issue     = (state == ST_RUN) && can_issue && !run_done;

  always_comb begin
    priority if (pre_valid) begin
      last_now = 1'b0;
    end else if (word_left) begin
      last_now = ((LW+1)'(widx) + (LW+1)'(1) == (LW+1)'(wlen)) && (tail_n == 2'd0);
    end else begin
      last_now = (tail_n == 2'd1);
    end
  end

  // placement of the pending word on the current line
  always_comb begin
    need = NEED_W'(pos) + NEED_W'(len) + NEED_W'(pos != '0);
    brk  = (pos != '0) && (need > NEED_W'(line_width));
    sp   = (pos != '0) && !brk;
    npos = (brk ? '0 : NEED_W'(pos)) + NEED_W'(sp) + NEED_W'(len);
    novf = (len != '0) && (npos > NEED_W'(line_width));
  end

  assign res_wr     = s1_valid;
  assign res.data   = s1_lit ? s1_byte : mem_rdata;
  assign res.last   = s1_last;
  assign res.ovf    = ovf;
  assign res.trunc  = trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      wlen      <= '0;
      widx      <= '0;
      pos       <= '0;
      pre_valid <= 1'b0;
      tail_n    <= 2'd0;
      ovf       <= 1'b0;
      trunc     <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= issue;
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.op)
              OP_STORE: len   <= len + 1'b1;
              OP_DROP:  trunc <= 1'b1;
              default: begin
                wlen      <= len;
                widx      <= '0;
                len       <= '0;
                pre_valid <= (len != '0) && (brk || sp);
                pre_byte  <= brk ? CH_NL : CH_SP;
                if (novf) begin
                  ovf <= 1'b1;
                end
                if (cmd.op == OP_PARA || cmd.op == OP_EOT) begin
                  pos <= '0;
                end else if (len != '0) begin
                  pos <= npos[POS_W-1:0];
                end
                tail_n <= (cmd.op == OP_PARA) ? 2'd2 : (cmd.op == OP_EOT) ? 2'd1 : 2'd0;
                state  <= ST_RUN;
              end
            endcase
          end
        end
        ST_RUN: begin
          if (run_done) begin
            state <= ST_IDLE;
          end else if (issue) begin
            priority if (pre_valid) begin
              pre_valid <= 1'b0;
            end else if (word_left) begin
              widx <= widx + 1'b1;
            end else begin
              tail_n <= tail_n - 2'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_lit  <= pre_valid || !word_left;
      s1_byte <= pre_valid ? pre_byte : CH_NL;
      s1_last <= last_now;
    end
  end

  // word store
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_STORE) begin
      mem[len[AW-1:0]] <= cmd.chr;
    end
    if (issue && !pre_valid && word_left) begin
      mem_rdata <= mem[widx[AW-1:0]];
    end
  end

endmodule

/* src/text_word_wrapper.sv */
// channel   direction  handshake              payload
// input     in         push / full            action, char_code
// result    out        pop / empty            out_byte, last_of_run, line_overflow,
//                                             word_truncated
// config    in         cfg_valid / cfg_ready  cfg_data (line_width)
//
// The emit engine stores a text byte in the word store, or drops it once the word
// is full; whitespace and end of text start a run that emits the bytes, one per
// cycle while the result queue has room, from the word store's single read port.
// Input and emit engine are split by a 4-word command queue; results leave
// through a 4-word queue, so either side may stall without blocking the other.
// Synchronous reset; line_width resets to 80, cfg_ready is always high.
module text_word_wrapper #(
  parameter int MAX_WORD = tww_pkg::MAX_WORD_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     action,
  input  logic [7:0]               char_code,
  output logic                     empty,
  input  logic                     pop,
  output logic [7:0]               out_byte,
  output logic                     last_of_run,
  output logic                     line_overflow,
  output logic                     word_truncated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tww_pkg::LW_W-1:0] cfg_data
);

  import tww_pkg::*;

  localparam int OCW = $clog2(OUTQ_DEPTH + 1);
  localparam int QCW = $clog2(CMDQ_DEPTH + 1);

  logic [LW_W-1:0] line_width;
  logic            cmd_wr;
  cmd_t            cmd_in;
  cmd_t            cmd_out;
  logic            cmd_empty;
  logic            cmd_pop;
  logic [QCW-1:0]  cmd_count;
  logic            res_wr;
  res_t            res_in;
  res_t            res_out;
  logic            res_full;
  logic [OCW-1:0]  res_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      line_width <= cfg_data;
    end
  end

  tww_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (full),
    .action    (action),
    .char_code (char_code),
    .cmd_wr    (cmd_wr),
    .cmd       (cmd_in)
  );

  tww_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMDQ_DEPTH)) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  tww_back #(.MAX_WORD(MAX_WORD), .OUT_DEPTH(OUTQ_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .res_count  (res_count),
    .res_wr     (res_wr),
    .res        (res_in)
  );

  tww_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUTQ_DEPTH)) u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty),
    .count   (res_count)
  );

  assign out_byte       = res_out.data;
  assign last_of_run    = res_out.last;
  assign line_overflow  = res_out.ovf;
  assign word_truncated = res_out.trunc;

endmodule

/* src/tww_checker.sv */
module tww_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     push,
  input logic                     full,
  input logic                     action,
  input logic [7:0]               char_code,
  input logic                     empty,
  input logic                     pop,
  input logic [7:0]               out_byte,
  input logic                     last_of_run,
  input logic                     line_overflow,
  input logic                     word_truncated,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [tww_pkg::LW_W-1:0] cfg_data
);

  logic seen_ovf;
  logic seen_trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_ovf   <= 1'b0;
      seen_trunc <= 1'b0;
    end else if (pop && !empty) begin
      if (line_overflow) begin
        seen_ovf <= 1'b1;
      end
      if (word_truncated) begin
        seen_trunc <= 1'b1;
      end
    end
  end

  // sticky flags never drop once a word has carried them
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    !empty && seen_ovf |-> line_overflow)
    else $error("line_overflow fell after being set");

  a_trunc_sticky: assert property (@(posedge clk) disable iff (rst)
    !empty && seen_trunc |-> word_truncated)
    else $error("word_truncated fell after being set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(!empty && !pop) |->
      !empty && $stable(out_byte) && $stable(last_of_run))
    else $error("waiting result changed");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> empty && !full)
    else $error("queues not clear after reset");

endmodule

bind text_word_wrapper tww_checker u_chk (.*);
